@@ design/mtzs_pkg.sv @@
// shared widths and control types for the settlement block
package mtzs_pkg;

  localparam int PayerW  = 4;
  localparam int AmountW = 10;
  localparam int ResultW = 5;

  // balance unit to subset engine
  typedef struct packed {
    logic push;
    logic start;
  } dp_req_t;

  // subset engine back to balance unit
  typedef struct packed {
    logic busy;
    logic done;
  } dp_rsp_t;

endpackage

@@ design/mtzs_in_if.sv @@
// transaction input channel
interface mtzs_in_if;
  logic                            valid;
  logic                            ready;
  logic [mtzs_pkg::PayerW-1:0]     payer;
  logic [mtzs_pkg::PayerW-1:0]     payee;
  logic [mtzs_pkg::AmountW-1:0]    amount;
  logic                            last;

  modport source (output valid, payer, payee, amount, last, input ready);
  modport sink   (input valid, payer, payee, amount, last, output ready);
endinterface

@@ design/mtzs_out_if.sv @@
// settlement result channel
interface mtzs_out_if;
  logic                            valid;
  logic                            ready;
  logic [mtzs_pkg::ResultW-1:0]    min_transfers;
  logic                            overflow;

  modport source (output valid, min_transfers, overflow, input ready);
  modport sink   (input valid, min_transfers, overflow, output ready);
endinterface

@@ design/mtzs_dp.sv @@
// subset dynamic program over the debt list, table held in one synchronous memory
module mtzs_dp #(
  parameter int ACCOUNTS     = 16,
  parameter int BALANCE_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtzs_pkg::dp_req_t                 req_i,
  input  logic signed [BALANCE_BITS-1:0]    debt_i,
  output mtzs_pkg::dp_rsp_t                 rsp_o,
  output logic [mtzs_pkg::ResultW-1:0]      min_transfers_o
);

  localparam int AW    = ACCOUNTS;
  localparam int IW    = $clog2(ACCOUNTS);
  localparam int CW    = $clog2(ACCOUNTS + 1);
  localparam int GW    = CW;
  localparam int SW    = BALANCE_BITS + $clog2(ACCOUNTS);
  localparam int Depth = 1 << ACCOUNTS;

  typedef enum logic [5:0] {
    DpIdle  = 6'b000001,
    DpInit  = 6'b000010,
    DpScan  = 6'b000100,
    DpWait  = 6'b001000,
    DpWrite = 6'b010000,
    DpDone  = 6'b100000
  } dp_state_e;

  dp_state_e state_q, state_d;

  logic signed [BALANCE_BITS-1:0] debt_q [ACCOUNTS];
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  mask_q, mask_d;
  logic [AW-1:0]  full_q, full_d;
  logic [IW-1:0]  j_q, j_d;
  logic           first_q, first_d;
  logic [GW-1:0]  best_q, best_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic [mtzs_pkg::ResultW-1:0] res_q, res_d;

  // read pipeline tags
  logic           rd_vld_q, rd_first_q, rd_zero_q;
  logic [IW-1:0]  rd_j_q;

  logic [SW+GW-1:0] mem [Depth];
  logic [SW+GW-1:0] rdata_q;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [SW+GW-1:0] wr_data;
  logic [GW-1:0]    rd_gc;
  logic signed [SW-1:0] rd_sum;
  logic [GW-1:0]    gc_new;

  assign rd_addr = mask_q ^ (AW'(1) << j_q);
  assign rd_en   = (state_q == DpScan) && mask_q[j_q];

  // the empty subset reads as zero sum, zero groups
  assign rd_gc  = rd_zero_q ? '0 : rdata_q[GW-1:0];
  assign rd_sum = rd_zero_q ? '0 : rdata_q[SW+GW-1:GW];
  assign gc_new = best_q + GW'(sum_q == '0);

  assign wr_en   = (state_q == DpWrite);
  assign wr_data = {sum_q, gc_new};

  // the write in DpWrite lands before the next mask issues its first read in DpScan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[mask_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      debt_q[cnt_q[IW-1:0]] <= debt_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mask_d  = mask_q;
    full_d  = full_q;
    j_d     = j_q;
    first_d = first_q;
    best_d  = best_q;
    sum_d   = sum_q;
    res_d   = res_q;

    if (req_i.push) begin
      cnt_d = cnt_q + CW'(1);
    end

    // fold in returning reads
    if (rd_vld_q) begin
      if (rd_gc > best_q) begin
        best_d = rd_gc;
      end
      if (rd_first_q) begin
        sum_d = rd_sum + SW'(debt_q[rd_j_q]);
      end
    end

    case (state_q)
      DpIdle: begin
        if (req_i.start) begin
          state_d = DpInit;
        end
      end
      DpInit: begin
        full_d  = AW'((64'd1 << cnt_q) - 64'd1);
        mask_d  = AW'(1);
        j_d     = '0;
        first_d = 1'b1;
        best_d  = '0;
        if (cnt_q == '0) begin
          res_d   = '0;
          state_d = DpDone;
        end else begin
          state_d = DpScan;
        end
      end
      DpScan: begin
        if (rd_en) begin
          first_d = 1'b0;
        end
        j_d = j_q + IW'(1);
        if (CW'(j_q) == cnt_q - CW'(1)) begin
          state_d = DpWait;
        end
      end
      DpWait: begin
        state_d = DpWrite;
      end
      DpWrite: begin
        if (mask_q == full_q) begin
          res_d   = mtzs_pkg::ResultW'(cnt_q) - mtzs_pkg::ResultW'(gc_new);
          state_d = DpDone;
        end else begin
          mask_d  = mask_q + AW'(1);
          j_d     = '0;
          first_d = 1'b1;
          best_d  = '0;
          state_d = DpScan;
        end
      end
      DpDone: begin
        cnt_d   = '0;
        state_d = DpIdle;
      end
      default: begin
        state_d = DpIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= DpIdle;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      rd_zero_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_en;
      rd_first_q <= first_q;
      rd_zero_q  <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    full_q  <= full_d;
    j_q     <= j_d;
    first_q <= first_d;
    best_q  <= best_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    rd_j_q  <= j_q;
  end

  assign rsp_o.busy      = (state_q != DpIdle);
  assign rsp_o.done      = (state_q == DpDone);
  assign min_transfers_o = res_q;

endmodule

@@ design/min_transfers_zero_sum_subset_dp.sv @@
// top level: balance table, debt collection and result register
//
//   channel  dir  payload                               transaction
//   in_i     in   payer, payee, amount, last            valid & ready
//   out_o    out  min_transfers, overflow               valid & ready
//
// a transaction steps through accept, payer update and payee update on the
// single-port balance table. after a last transaction, the collect step walks
// every account and pushes each nonzero balance to the subset engine, which
// reads its table through its memory port, one read per set bit of each mask.
// reset clears control only; balances carry per-account valid bits and every
// subset entry is written before it is read, so no clearing pass follows reset.
// the result register holds under a stalled consumer; the next batch waits in StDone.
module min_transfers_zero_sum_subset_dp #(
  parameter int ACCOUNTS     = 16,
  parameter int BALANCE_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtzs_in_if.sink    in_i,
  mtzs_out_if.source out_o
);

  localparam int IW = $clog2(ACCOUNTS);
  localparam int EW = ((BALANCE_BITS > mtzs_pkg::AmountW) ?
                       BALANCE_BITS : mtzs_pkg::AmountW) + 2;
  localparam logic signed [EW-1:0] BalMax = EW'({1'b0, {(BALANCE_BITS-1){1'b1}}});
  localparam logic signed [EW-1:0] BalMin = ~BalMax;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StPayer   = 6'b000010,
    StPayee   = 6'b000100,
    StCollect = 6'b001000,
    StSettle  = 6'b010000,
    StDone    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [mtzs_pkg::PayerW-1:0]  payer_q, payee_q;
  logic [mtzs_pkg::AmountW-1:0] amount_q;
  logic                         last_q;

  logic signed [BALANCE_BITS-1:0] bal_q [ACCOUNTS];
  logic [ACCOUNTS-1:0]            bal_vld_q, bal_vld_d;
  logic                           ovf_q, ovf_d;
  logic [IW-1:0]                  coll_j_q, coll_j_d;

  logic                           out_valid_q, out_valid_d;
  logic [mtzs_pkg::ResultW-1:0]   out_mt_q;
  logic                           out_ovf_q;

  logic                           in_accept;
  logic                           out_load;
  logic [IW-1:0]                  rd_idx;
  logic signed [BALANCE_BITS-1:0] bal_rd;
  logic signed [EW-1:0]           acc_ext, amt_ext, sum_ext;
  logic                           hit_hi, hit_lo;
  logic signed [BALANCE_BITS-1:0] bal_new;
  logic                           bal_we;
  logic                           payer_ok, payee_ok;

  mtzs_pkg::dp_req_t              dp_req;
  mtzs_pkg::dp_rsp_t              dp_rsp;
  logic [mtzs_pkg::ResultW-1:0]   dp_result;

  assign in_i.ready = (state_q == StIdle);
  assign in_accept  = in_i.valid && in_i.ready;

  assign payer_ok = (32'(payer_q) < ACCOUNTS);
  assign payee_ok = (32'(payee_q) < ACCOUNTS);

  // one read port on the balance table, shared by the update and collect steps
  always_comb begin
    case (state_q)
      StPayer: rd_idx = IW'(payer_q);
      StPayee: rd_idx = IW'(payee_q);
      default: rd_idx = coll_j_q;
    endcase
  end

  assign bal_rd = bal_vld_q[rd_idx] ? bal_q[rd_idx] : '0;

  // saturating add of the amount, subtract on the payee side
  assign acc_ext = EW'(bal_rd);
  assign amt_ext = EW'(amount_q);
  assign sum_ext = (state_q == StPayee) ? acc_ext - amt_ext : acc_ext + amt_ext;
  assign hit_hi  = (sum_ext > BalMax);
  assign hit_lo  = (sum_ext < BalMin);
  assign bal_new = hit_hi ? BalMax[BALANCE_BITS-1:0] :
                   hit_lo ? BalMin[BALANCE_BITS-1:0] : sum_ext[BALANCE_BITS-1:0];

  assign bal_we = ((state_q == StPayer) && payer_ok) || ((state_q == StPayee) && payee_ok);

  assign out_load = (state_q == StDone) && (!out_valid_q || out_o.ready);

  assign dp_req.push  = (state_q == StCollect) && (bal_rd != '0);
  assign dp_req.start = (state_q == StCollect) && (coll_j_q == IW'(ACCOUNTS - 1));

  always_comb begin
    state_d   = state_q;
    bal_vld_d = bal_vld_q;
    ovf_d     = ovf_q;
    coll_j_d  = coll_j_q;

    if (bal_we) begin
      bal_vld_d[rd_idx] = 1'b1;
      if (hit_hi || hit_lo) begin
        ovf_d = 1'b1;
      end
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StPayer;
        end
      end
      StPayer: begin
        state_d = StPayee;
      end
      StPayee: begin
        coll_j_d = '0;
        state_d  = last_q ? StCollect : StIdle;
      end
      StCollect: begin
        coll_j_d = coll_j_q + IW'(1);
        if (dp_req.start) begin
          state_d = StSettle;
        end
      end
      StSettle: begin
        if (dp_rsp.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          bal_vld_d = '0;
          ovf_d     = 1'b0;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bal_vld_q   <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bal_vld_q   <= bal_vld_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      payer_q  <= in_i.payer;
      payee_q  <= in_i.payee;
      amount_q <= in_i.amount;
      last_q   <= in_i.last;
    end
    if (bal_we) begin
      bal_q[rd_idx] <= bal_new;
    end
    if (out_load) begin
      out_mt_q  <= dp_result;
      out_ovf_q <= ovf_q;
    end
    coll_j_q <= coll_j_d;
  end

  mtzs_dp #(
    .ACCOUNTS     (ACCOUNTS),
    .BALANCE_BITS (BALANCE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (dp_req),
    .debt_i          (bal_rd),
    .rsp_o           (dp_rsp),
    .min_transfers_o (dp_result)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.min_transfers = out_mt_q;
  assign out_o.overflow      = out_ovf_q;

`ifndef ASSERT_OFF
  // a result only appears after the engine finished a batch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result raised without a finished settlement");

  // no transaction is taken while the subset engine runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_rsp.busy |-> !in_accept)
    else $error("transaction accepted during settlement");

  // handing off a result leaves a clean balance table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_load) |-> (bal_vld_q == '0) && !ovf_q)
    else $error("balances not cleared after result");
`endif

endmodule
